>>> hdl/ppp_pkg.sv
// Package for the palette pixel plotter: request and response structs,
// request type codes and fixed field widths.
// Depends on nothing; ppp_scaler and the top level in hdl/ import it.
package ppp_pkg;

   localparam int RGB_W   = 24;
   localparam int COORD_W = 10;
   localparam int PSEL_W  = 4;
   localparam int ENTRY_W = 8;
   localparam int TYPE_W  = 2;

   localparam logic [TYPE_W-1:0] REQ_PAL_WRITE = 2'd0;
   localparam logic [TYPE_W-1:0] REQ_PAL_PIXEL = 2'd1;
   localparam logic [TYPE_W-1:0] REQ_RGB_PIXEL = 2'd2;
   localparam logic [TYPE_W-1:0] REQ_READOUT   = 2'd3;

   typedef struct packed {
      logic [TYPE_W-1:0]  req_type;
      logic [COORD_W-1:0] pos_x;
      logic [COORD_W-1:0] pos_y;
      logic [PSEL_W-1:0]  palette_select;
      logic [ENTRY_W-1:0] color_index;
      logic [ENTRY_W-1:0] index_offset;
      logic               skip_zero;
      logic [RGB_W-1:0]   rgb_value;
      logic               combine_or;
   } request_type;

   typedef struct packed {
      logic [RGB_W-1:0] read_rgb;
      logic             written;
      logic             clipped;
   } response_type;

   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
   } coord_pair_type;

endpackage

>>> hdl/ppp_ram.sv
// Simple dual-port synchronous RAM: one write port, one read port,
// read data registered. Depends on nothing.
module ppp_ram #(
   parameter int DEPTH = 4096,
   parameter int WIDTH = 24
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/ppp_scaler.sv
// Nearest-neighbor coordinate scaler: output coordinates to frame coordinates.
// Two registered stages: constant multiply, then reciprocal multiply.
// Depends on ppp_pkg.
module ppp_scaler #(
   parameter int FRAME_WIDTH  = 320,
   parameter int FRAME_HEIGHT = 200,
   parameter int OUT_WIDTH    = 640,
   parameter int OUT_HEIGHT   = 400
) (
   input  logic                   clock,
   input  ppp_pkg::coord_pair_type out_coord,
   output ppp_pkg::coord_pair_type frame_coord
);
   import ppp_pkg::*;

   // Coordinate times frame size stays below 2^20; a 2^-32 reciprocal is exact there.
   localparam int PROD_W  = 20;
   localparam int RECIP_W = 29;
   localparam int FULL_W  = PROD_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP_X =
      RECIP_W'(((64'd1 << 32) + 64'(OUT_WIDTH) - 64'd1) / 64'(OUT_WIDTH));
   localparam logic [RECIP_W-1:0] RECIP_Y =
      RECIP_W'(((64'd1 << 32) + 64'(OUT_HEIGHT) - 64'd1) / 64'(OUT_HEIGHT));

   logic [PROD_W-1:0]  prod_x_ff, prod_y_ff;
   logic [PROD_W-1:0]  prod_x_in, prod_y_in;
   logic [FULL_W-1:0]  full_x, full_y;
   coord_pair_type     scaled_ff, scaled_in;

   assign prod_x_in = PROD_W'(32'(out_coord.x) * FRAME_WIDTH);
   assign prod_y_in = PROD_W'(32'(out_coord.y) * FRAME_HEIGHT);

   assign full_x = FULL_W'(prod_x_ff) * FULL_W'(RECIP_X);
   assign full_y = FULL_W'(prod_y_ff) * FULL_W'(RECIP_Y);

   assign scaled_in.x = full_x[32 +: COORD_W];
   assign scaled_in.y = full_y[32 +: COORD_W];

   always_ff @(posedge clock) begin
      prod_x_ff <= prod_x_in;
      prod_y_ff <= prod_y_in;
      scaled_ff <= scaled_in;
   end

   assign frame_coord = scaled_ff;

endmodule

>>> hdl/palette_pixel_plotter_top.sv
// Palette pixel plotter top level: request sequencer, frame and palette RAMs,
// readout scaler, response register. Depends on ppp_pkg, ppp_ram, ppp_scaler.
// Sequence: plots and palette writes pass ST_ADDR, ST_READ and ST_DONE after acceptance;
//   readouts first pass ST_SCALE and ST_DIVIDE for the scaler's multipliers.
// One transaction at a time: no new request is taken until the last one's response is
//   registered, following the frame RAM read-modify-write sequence.
// Reset: synchronous; afterwards the frame RAM is cleared one pixel per cycle, all
//   FRAME_WIDTH*FRAME_HEIGHT pixels, with req_ready low. Palettes are not cleared.
module palette_pixel_plotter_top #(
   parameter int FRAME_WIDTH   = 320,
   parameter int FRAME_HEIGHT  = 200,
   parameter int OUT_WIDTH     = 640,
   parameter int OUT_HEIGHT    = 400,
   parameter int PALETTE_COUNT = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  ppp_pkg::request_type  req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output ppp_pkg::response_type rsp_payload
);
   import ppp_pkg::*;

   localparam int FRAME_DEPTH = FRAME_WIDTH * FRAME_HEIGHT;
   localparam int SLOT_W      = $clog2(FRAME_DEPTH);
   localparam int PAL_DEPTH   = PALETTE_COUNT * 256;
   localparam int PAL_ADDR_W  = $clog2(PAL_DEPTH);

   localparam logic [SLOT_W-1:0]  LAST_SLOT = SLOT_W'(FRAME_DEPTH - 1);
   localparam logic [COORD_W:0]   FW_LIMIT  = (COORD_W+1)'(FRAME_WIDTH);
   localparam logic [COORD_W:0]   FH_LIMIT  = (COORD_W+1)'(FRAME_HEIGHT);
   localparam logic [COORD_W:0]   OW_LIMIT  = (COORD_W+1)'(OUT_WIDTH);
   localparam logic [COORD_W:0]   OH_LIMIT  = (COORD_W+1)'(OUT_HEIGHT);
   localparam logic [PSEL_W:0]    PAL_LIMIT = (PSEL_W+1)'(PALETTE_COUNT);

   // Sequencer states
   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_SCALE  = 3'd2;
   localparam logic [2:0] ST_DIVIDE = 3'd3;
   localparam logic [2:0] ST_ADDR   = 3'd4;
   localparam logic [2:0] ST_READ   = 3'd5;
   localparam logic [2:0] ST_DONE   = 3'd6;

   logic [2:0]            state_ff, state_in;
   logic [SLOT_W-1:0]     clr_addr_ff, clr_addr_in;
   request_type           req_ff;
   logic [SLOT_W-1:0]     slot_ff, slot_in;
   logic [PAL_ADDR_W-1:0] pal_rd_addr_ff, pal_rd_addr_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   response_type          rsp_ff, rsp_in;

   coord_pair_type        out_coord, frame_coord;
   logic [COORD_W-1:0]    col, row;
   logic [ENTRY_W-1:0]    entry;

   logic                  frame_wr_en;
   logic [SLOT_W-1:0]     frame_wr_addr;
   logic [RGB_W-1:0]      frame_wr_data, frame_rd_data;
   logic                  pal_wr_en;
   logic [PAL_ADDR_W-1:0] pal_wr_addr;
   logic [RGB_W-1:0]      pal_rd_data;

   logic                  out_free, accept, finish;
   logic                  pal_ok, in_frame, in_out, transparent;
   logic                  do_frame_wr, do_pal_wr;
   response_type          result;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign finish    = (state_ff == ST_DONE) && out_free;

   // Scale output coordinates to frame coordinates for readouts
   assign out_coord.x = req_ff.pos_x;
   assign out_coord.y = req_ff.pos_y;

   ppp_scaler #(
      .FRAME_WIDTH (FRAME_WIDTH),
      .FRAME_HEIGHT(FRAME_HEIGHT),
      .OUT_WIDTH   (OUT_WIDTH),
      .OUT_HEIGHT  (OUT_HEIGHT)
   ) u_scaler (
      .clock      (clock),
      .out_coord  (out_coord),
      .frame_coord(frame_coord)
   );

   // Address generation: pixel slot and palette entry
   always_comb begin
      if (req_ff.req_type == REQ_READOUT) begin
         col = frame_coord.x;
         row = frame_coord.y;
      end else begin
         col = req_ff.pos_x;
         row = req_ff.pos_y;
      end
      entry          = req_ff.color_index + req_ff.index_offset;
      slot_in        = SLOT_W'(32'(row) * FRAME_WIDTH + 32'(col));
      pal_rd_addr_in = PAL_ADDR_W'({req_ff.palette_select, entry});
   end

   // Request classification, valid while the transaction is held in req_ff
   assign pal_ok      = {1'b0, req_ff.palette_select} < PAL_LIMIT;
   assign in_frame    = ({1'b0, req_ff.pos_x} < FW_LIMIT) && ({1'b0, req_ff.pos_y} < FH_LIMIT);
   assign in_out      = ({1'b0, req_ff.pos_x} < OW_LIMIT) && ({1'b0, req_ff.pos_y} < OH_LIMIT);
   assign transparent = req_ff.skip_zero && (req_ff.color_index == '0);

   always_comb begin
      result        = '0;
      do_frame_wr   = 1'b0;
      do_pal_wr     = 1'b0;
      frame_wr_data = req_ff.rgb_value;
      case (req_ff.req_type)
         REQ_PAL_WRITE: begin
            do_pal_wr      = pal_ok;
            result.written = pal_ok;
         end
         REQ_PAL_PIXEL: begin
            frame_wr_data = pal_rd_data;
            if (pal_ok && !transparent) begin
               do_frame_wr    = in_frame;
               result.written = in_frame;
               result.clipped = !in_frame;
            end
         end
         REQ_RGB_PIXEL: begin
            // OR mode merges into the pixel just read back
            if (req_ff.combine_or) begin
               frame_wr_data = frame_rd_data | req_ff.rgb_value;
            end
            do_frame_wr    = in_frame;
            result.written = in_frame;
            result.clipped = !in_frame;
         end
         REQ_READOUT: begin
            if (in_out) begin
               result.read_rgb = frame_rd_data;
            end else begin
               result.clipped = 1'b1;
            end
         end
         default: begin
            result = '0;
         end
      endcase
   end

   // Frame RAM write port: clearing sweep after reset, else the update
   assign frame_wr_en   = (state_ff == ST_CLEAR) || (finish && do_frame_wr);
   assign frame_wr_addr = (state_ff == ST_CLEAR) ? clr_addr_ff : slot_ff;

   ppp_ram #(
      .DEPTH(FRAME_DEPTH),
      .WIDTH(RGB_W)
   ) u_frame_ram (
      .clock  (clock),
      .wr_en  (frame_wr_en),
      .wr_addr(frame_wr_addr),
      .wr_data((state_ff == ST_CLEAR) ? '0 : frame_wr_data),
      .rd_addr(slot_ff),
      .rd_data(frame_rd_data)
   );

   assign pal_wr_en   = finish && do_pal_wr;
   assign pal_wr_addr = PAL_ADDR_W'({req_ff.palette_select, req_ff.color_index});

   ppp_ram #(
      .DEPTH(PAL_DEPTH),
      .WIDTH(RGB_W)
   ) u_palette_ram (
      .clock  (clock),
      .wr_en  (pal_wr_en),
      .wr_addr(pal_wr_addr),
      .wr_data(req_ff.rgb_value),
      .rd_addr(pal_rd_addr_ff),
      .rd_data(pal_rd_data)
   );

   // Sequencer: one transaction at a time, so a write always lands
   // before the next read of the same pixel
   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == LAST_SLOT) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = (req_payload.req_type == REQ_READOUT) ? ST_SCALE : ST_ADDR;
            end
         end
         ST_SCALE:  state_in = ST_DIVIDE;
         ST_DIVIDE: state_in = ST_ADDR;
         ST_ADDR:   state_in = ST_READ;
         ST_READ:   state_in = ST_DONE;
         ST_DONE: begin
            // Hold until the response register frees up
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = result;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_payload;
      end
      if (state_ff == ST_ADDR) begin
         slot_ff        <= slot_in;
         pal_rd_addr_ff <= pal_rd_addr_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef ASSERT_OFF
   a_no_rsp_during_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !rsp_valid_ff)
      else $error("response raised during frame clear");

   a_written_xor_clipped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.written && rsp_ff.clipped))
      else $error("response both written and clipped");

   a_readout_only_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ff.read_rgb != '0)) |-> (!rsp_ff.written && !rsp_ff.clipped))
      else $error("read data on a non-readout response");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_SCALE || state_ff == ST_ADDR))
      else $error("accepted transaction did not start");

   a_finish_responds: assert property (@(posedge clock) disable iff (reset)
      finish |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("finished transaction produced no response");
`endif

endmodule

>>> verif/palette_pixel_plotter_top_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for palette_pixel_plotter_top: a directed opening, then random
// plots, palette writes and readouts, all checked against an in-bench frame/palette copy.
// Depends on ppp_pkg and the plotter RTL; reads no files.
module palette_pixel_plotter_top_tb;
   import ppp_pkg::*;

   localparam int FRAME_WIDTH   = 320;
   localparam int FRAME_HEIGHT  = 200;
   localparam int OUT_WIDTH     = 640;
   localparam int OUT_HEIGHT    = 400;
   localparam int PALETTE_COUNT = 16;
   localparam int FRAME_PIXELS  = FRAME_WIDTH * FRAME_HEIGHT;
   localparam int PALETTE_SLOTS = PALETTE_COUNT * 256;

   localparam int CLK_PERIOD    = 10;
   localparam int RESET_CYCLES  = 7;
   localparam int RANDOM_ITEMS  = 925;
   // Leave room for a stray late response.
   localparam int DRAIN_CYCLES  = 20;
   // Receiver pressure: stall this long once this many responses have arrived.
   localparam int HOLD_AT       = 300;
   localparam int HOLD_CYCLES   = 250;

   // Track the frame and palette contents and the responses still owed by the block.
   class plot_scoreboard;
      bit [RGB_W-1:0] frame_pix [FRAME_PIXELS];
      bit [RGB_W-1:0] palette_ram [PALETTE_SLOTS];
      response_type   pending_results [$];
      int             error_count;

      // Apply one transaction to the frame/palette copy and return its response.
      function response_type predict_result(request_type r);
         response_type res;
         int slot;
         int src_x;
         int src_y;
         bit [ENTRY_W-1:0] entry;
         res = '0;
         case (r.req_type)
            REQ_PAL_WRITE: begin
               if (r.palette_select < PALETTE_COUNT) begin
                  palette_ram[int'(r.palette_select) * 256 + int'(r.color_index)] = r.rgb_value;
                  res.written = 1'b1;
               end
            end
            REQ_PAL_PIXEL: begin
               // Transparent index and out-of-range palette leave everything untouched.
               if (r.palette_select < PALETTE_COUNT && !(r.skip_zero && r.color_index == 0)) begin
                  if (r.pos_x < FRAME_WIDTH && r.pos_y < FRAME_HEIGHT) begin
                     entry = r.color_index + r.index_offset;
                     slot  = int'(r.pos_x) + int'(r.pos_y) * FRAME_WIDTH;
                     frame_pix[slot] = palette_ram[int'(r.palette_select) * 256 + int'(entry)];
                     res.written = 1'b1;
                  end else begin
                     res.clipped = 1'b1;
                  end
               end
            end
            REQ_RGB_PIXEL: begin
               if (r.pos_x < FRAME_WIDTH && r.pos_y < FRAME_HEIGHT) begin
                  slot = int'(r.pos_x) + int'(r.pos_y) * FRAME_WIDTH;
                  if (r.combine_or) frame_pix[slot] = frame_pix[slot] | r.rgb_value;
                  else frame_pix[slot] = r.rgb_value;
                  res.written = 1'b1;
               end else begin
                  res.clipped = 1'b1;
               end
            end
            default: begin
               // Nearest-neighbor: scale output coordinates down to frame coordinates.
               if (r.pos_x < OUT_WIDTH && r.pos_y < OUT_HEIGHT) begin
                  src_x = int'(r.pos_x) * FRAME_WIDTH / OUT_WIDTH;
                  src_y = int'(r.pos_y) * FRAME_HEIGHT / OUT_HEIGHT;
                  if (src_x < FRAME_WIDTH && src_y < FRAME_HEIGHT)
                     res.read_rgb = frame_pix[src_x + src_y * FRAME_WIDTH];
               end else begin
                  res.clipped = 1'b1;
               end
            end
         endcase
         return res;
      endfunction

      function void note_request(request_type r);
         pending_results.push_back(predict_result(r));
      endfunction

      function void check_response(response_type got);
         response_type want;
         if (pending_results.size() == 0) begin
            $display("%0t: response with none pending, expected nothing, actual %h", $time, got);
            error_count++;
            return;
         end
         want = pending_results.pop_front();
         if (got.read_rgb !== want.read_rgb) begin
            $display("%0t: read_rgb mismatch, expected %h, actual %h",
                     $time, want.read_rgb, got.read_rgb);
            error_count++;
         end
         if (got.written !== want.written) begin
            $display("%0t: written mismatch, expected %b, actual %b",
                     $time, want.written, got.written);
            error_count++;
         end
         if (got.clipped !== want.clipped) begin
            $display("%0t: clipped mismatch, expected %b, actual %b",
                     $time, want.clipped, got.clipped);
            error_count++;
         end
      endfunction
   endclass

   logic         clock       = 1'b0;
   logic         reset       = 1'b1;
   logic         req_valid   = 1'b0;
   logic         req_ready;
   request_type  req_payload = '0;
   logic         rsp_valid;
   logic         rsp_ready   = 1'b0;
   response_type rsp_payload;

   plot_scoreboard board = new();

   // Palette slots (palette * 256 + entry) written so far; palette plots only look these up,
   // since an unwritten palette entry has no defined contents.
   int entry_log [$];
   bit sender_calm   = 1'b0;
   int rsp_count     = 0;
   int hold_left     = 0;
   bit hold_done     = 1'b0;

   always #(CLK_PERIOD / 2) clock = ~clock;

   palette_pixel_plotter_top #(
      .FRAME_WIDTH   (FRAME_WIDTH),
      .FRAME_HEIGHT  (FRAME_HEIGHT),
      .OUT_WIDTH     (OUT_WIDTH),
      .OUT_HEIGHT    (OUT_HEIGHT),
      .PALETTE_COUNT (PALETTE_COUNT)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   // Offer one transaction and hold it until the block takes it. Drop valid for a random gap
   // beforehand now and then, unless this is a calm stretch.
   task automatic send_request(request_type r);
      if (!sender_calm && $urandom_range(0, 99) < 11) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (!req_ready);
      board.note_request(r);
      if (r.req_type == REQ_PAL_WRITE)
         entry_log.push_back(int'(r.palette_select) * 256 + int'(r.color_index));
   endtask

   function automatic request_type make_request(logic [TYPE_W-1:0] kind, int x, int y,
                                                int pal, int cidx, int offs, bit skip,
                                                logic [RGB_W-1:0] rgb, bit comb);
      request_type r;
      r.req_type       = kind;
      r.pos_x          = COORD_W'(x);
      r.pos_y          = COORD_W'(y);
      r.palette_select = PSEL_W'(pal);
      r.color_index    = ENTRY_W'(cidx);
      r.index_offset   = ENTRY_W'(offs);
      r.skip_zero      = skip;
      r.rgb_value      = rgb;
      r.combine_or     = comb;
      return r;
   endfunction

   // Pick a coordinate hugging either end of [0, limit) so plots and reads collide often.
   function automatic int hot_pick(int limit);
      if ($urandom_range(0, 1)) return $urandom_range(0, 5);
      return $urandom_range(limit - 6, limit - 1);
   endfunction

   function automatic coord_pair_type frame_coord();
      coord_pair_type c;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
         c.x = COORD_W'(hot_pick(FRAME_WIDTH));
         c.y = COORD_W'(hot_pick(FRAME_HEIGHT));
      end else if (pick < 85) begin
         c.x = COORD_W'($urandom_range(0, FRAME_WIDTH - 1));
         c.y = COORD_W'($urandom_range(0, FRAME_HEIGHT - 1));
      end else begin
         // Mostly off the frame, full field range.
         c.x = COORD_W'($urandom_range(0, 1023));
         c.y = COORD_W'($urandom_range(0, 1023));
      end
      return c;
   endfunction

   function automatic coord_pair_type out_coord();
      coord_pair_type c;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
         // Land on the hot frame pixels through the 2:1 scaler.
         c.x = COORD_W'(2 * hot_pick(FRAME_WIDTH) + int'($urandom_range(0, 1)));
         c.y = COORD_W'(2 * hot_pick(FRAME_HEIGHT) + int'($urandom_range(0, 1)));
      end else if (pick < 85) begin
         c.x = COORD_W'($urandom_range(0, OUT_WIDTH - 1));
         c.y = COORD_W'($urandom_range(0, OUT_HEIGHT - 1));
      end else begin
         c.x = COORD_W'($urandom_range(0, 1023));
         c.y = COORD_W'($urandom_range(0, 1023));
      end
      return c;
   endfunction

   // Fill every field with noise, then shape the fields that the chosen operation uses.
   function automatic request_type random_request();
      request_type    r;
      coord_pair_type c;
      int pick;
      int slot;
      r.pos_x          = COORD_W'($urandom_range(0, 1023));
      r.pos_y          = COORD_W'($urandom_range(0, 1023));
      r.palette_select = PSEL_W'($urandom_range(0, 15));
      r.color_index    = ENTRY_W'($urandom_range(0, 255));
      r.index_offset   = ENTRY_W'($urandom_range(0, 255));
      r.skip_zero      = 1'($urandom_range(0, 1));
      r.rgb_value      = RGB_W'($urandom_range(0, 24'hFFFFFF));
      r.combine_or     = 1'($urandom_range(0, 1));
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
         r.req_type = REQ_PAL_WRITE;
      end else if (pick < 45) begin
         r.req_type = REQ_PAL_PIXEL;
         c = frame_coord();
         r.pos_x = c.x;
         r.pos_y = c.y;
         slot = entry_log[$urandom_range(0, entry_log.size() - 1)];
         r.palette_select = PSEL_W'(slot / 256);
         // Force a transparent index now and then.
         if ($urandom_range(0, 9) == 0) begin
            r.skip_zero   = 1'b1;
            r.color_index = '0;
         end
         // Steer the wrapped sum onto a written entry.
         r.index_offset = ENTRY_W'((slot % 256) - int'(r.color_index));
      end else if (pick < 70) begin
         r.req_type = REQ_RGB_PIXEL;
         c = frame_coord();
         r.pos_x = c.x;
         r.pos_y = c.y;
      end else begin
         r.req_type = REQ_READOUT;
         c = out_coord();
         r.pos_x = c.x;
         r.pos_y = c.y;
      end
      return r;
   endfunction

   task automatic run_directed();
      // Readout straight after the clearing pass: frame must be zero.
      send_request(make_request(REQ_READOUT,     0,    0,  0,   0,   0, 0, 24'h000000, 0));
      // Seed the extreme entries of the first and last palettes.
      send_request(make_request(REQ_PAL_WRITE,   0,    0,  0,   0,   0, 0, 24'hFFFFFF, 0));
      send_request(make_request(REQ_PAL_WRITE,   0,    0,  0, 255,   0, 0, 24'h123456, 0));
      send_request(make_request(REQ_PAL_WRITE,   0,    0, 15, 255,   0, 0, 24'hA5A5A5, 0));
      send_request(make_request(REQ_PAL_WRITE,   0,    0, 15,   0,   0, 0, 24'h5A5A5A, 0));
      // Palette plots at the frame corners, including an index wrap past 255.
      send_request(make_request(REQ_PAL_PIXEL,   0,    0,  0,   0,   0, 0, 24'h000000, 0));
      send_request(make_request(REQ_PAL_PIXEL, 319,  199,  0,   1, 254, 0, 24'h000000, 0));
      send_request(make_request(REQ_PAL_PIXEL, 319,    0, 15, 255,   0, 0, 24'h000000, 0));
      send_request(make_request(REQ_PAL_PIXEL,   0,  199, 15, 255,   1, 1, 24'h000000, 0));
      // Transparent index: no write, and no clip even off the frame.
      send_request(make_request(REQ_PAL_PIXEL,   5,    5,  0,   0,   0, 1, 24'h000000, 0));
      send_request(make_request(REQ_PAL_PIXEL, 1023, 1023, 0,   0, 255, 1, 24'h000000, 0));
      // Palette plots just past the right and bottom edges.
      send_request(make_request(REQ_PAL_PIXEL, 320,    0,  0,   0,   0, 0, 24'h000000, 0));
      send_request(make_request(REQ_PAL_PIXEL,   0,  200, 15,   0, 255, 0, 24'h000000, 0));
      // Direct set, then OR on top of it and OR onto an empty pixel; then two off-frame plots.
      send_request(make_request(REQ_RGB_PIXEL,   1,    0,  0,   0,   0, 0, 24'hAAAAAA, 0));
      send_request(make_request(REQ_RGB_PIXEL,   1,    0,  0,   0,   0, 0, 24'h555555, 1));
      send_request(make_request(REQ_RGB_PIXEL,   2,    0,  0,   0,   0, 0, 24'h0F0F0F, 1));
      send_request(make_request(REQ_RGB_PIXEL, 1023, 1023, 0,   0,   0, 0, 24'hFFFFFF, 0));
      send_request(make_request(REQ_RGB_PIXEL, 320,  199,  0,   0,   0, 0, 24'hFFFFFF, 1));
      // Scaled readouts at the corners of the output and just past them.
      send_request(make_request(REQ_READOUT,     1,    1,  0,   0,   0, 0, 24'h000000, 0));
      send_request(make_request(REQ_READOUT,     2,    0,  0,   0,   0, 0, 24'h000000, 0));
      send_request(make_request(REQ_READOUT,   639,  399,  0,   0,   0, 0, 24'h000000, 0));
      send_request(make_request(REQ_READOUT,   638,    1,  0,   0,   0, 0, 24'h000000, 0));
      send_request(make_request(REQ_READOUT,   640,    0,  0,   0,   0, 0, 24'h000000, 0));
      send_request(make_request(REQ_READOUT,     0,  400,  0,   0,   0, 0, 24'h000000, 0));
      send_request(make_request(REQ_READOUT,  1023, 1023,  0,   0,   0, 0, 24'h000000, 0));
   endtask

   // Response side: sample the handshake as seen at this edge, then pick the next ready.
   // Once, hold ready low for a long stretch so the block backs up into its input.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         board.check_response(rsp_payload);
         rsp_count++;
      end
      if (hold_left > 0) begin
         hold_left--;
      end else if (!hold_done && rsp_count >= HOLD_AT) begin
         hold_left = HOLD_CYCLES;
         hold_done = 1'b1;
      end
      // Keep a calm stretch with ready held high.
      rsp_ready <= (hold_left == 0) &&
                   ((rsp_count >= 500 && rsp_count < 700) || $urandom_range(0, 99) >= 11);
   end

   // Main sequence: reset once, directed opening, random body, drain, verdict.
   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      // The block clears its frame after reset with req_ready low; send_request waits it out.
      run_directed();
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         sender_calm = (n >= 550 && n < 750);
         send_request(random_request());
      end
      req_valid <= 1'b0;
      while (board.pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // Watchdog: the clearing pass plus all transactions fit many times over in 5 ms.
   initial begin
      #5_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

>>> filelist.f
hdl/ppp_pkg.sv
hdl/ppp_ram.sv
hdl/ppp_scaler.sv
hdl/palette_pixel_plotter_top.sv
verif/palette_pixel_plotter_top_tb.sv
